// File: rtl/core/clcd_pkg.sv
// ----------------------------------------------------------------------------
// clcd_pkg
// Shared codes, command constants and control structs for the character LCD
// nibble command sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package clcd_pkg;

  // request operation codes
  localparam logic [1:0] OP_WRITE_CHAR = 2'd0;
  localparam logic [1:0] OP_CLEAR      = 2'd1;
  localparam logic [1:0] OP_SET_CURSOR = 2'd2;
  localparam logic [1:0] OP_INIT       = 2'd3;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W    = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_POWER_ON_WAIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_WAIT    = 2'd1;

  // configuration reset values
  localparam logic [7:0] POWER_ON_WAIT_RST = 8'd16;
  localparam logic [3:0] PULSE_WAIT_RST    = 4'd1;

  // display instructions
  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic [7:0] CMD_SET_DDRAM = 8'h80;

  // cursor limits
  localparam logic [2:0] MAX_ROW    = 3'd3;
  localparam logic [4:0] MAX_COLUMN = 5'd19;

  // init sequence
  localparam logic [2:0] INIT_LAST_IDX    = 3'd6;
  localparam logic [7:0] EXTRA_WAIT_FIRST  = 8'd5;
  localparam logic [7:0] EXTRA_WAIT_SECOND = 8'd1;

  // nibble phases of one byte
  localparam logic [1:0] PH_HI_STROBE = 2'd0;
  localparam logic [1:0] PH_HI_LATCH  = 2'd1;
  localparam logic [1:0] PH_LO_STROBE = 2'd2;
  localparam logic [1:0] PH_LO_LATCH  = 2'd3;

  // sequencer to nibble shifter
  typedef struct packed {
    logic       load;
    logic       advance;
    logic [7:0] cmd_byte;
  } shift_ctl_t;

  // nibble shifter to sequencer
  typedef struct packed {
    logic [3:0] nibble;
    logic       enable;
    logic       final_state;
  } shift_sts_t;

  // init command bytes in issue order
  function automatic logic [7:0] init_cmd(input logic [2:0] idx);
    logic [7:0] cmd;
    case (idx)
      3'd0:    cmd = 8'h03;
      3'd1:    cmd = 8'h03;
      3'd2:    cmd = 8'h02;
      3'd3:    cmd = 8'h28;
      3'd4:    cmd = 8'h01;
      3'd5:    cmd = 8'h0C;
      default: cmd = 8'h06;
    endcase
    return cmd;
  endfunction

  // display address of column zero of each row
  function automatic logic [7:0] row_base(input logic [1:0] row);
    logic [7:0] base;
    case (row)
      2'd0:    base = 8'h00;
      2'd1:    base = 8'h40;
      2'd2:    base = 8'h14;
      default: base = 8'h54;
    endcase
    return base;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/char_lcd_nibble_command_sequencer.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_command_sequencer
// Turns display requests into timed pin states for a 4-bit character LCD bus.
// ----------------------------------------------------------------------------
// Each accepted request yields a run of pin states, one per output transfer,
// the final one flagged by out_last. A write, clear or in-range set-cursor
// gives four states; initialize gives 29; a set-cursor outside rows 0-3 or
// columns 0-19 gives none. The nibble shifter steps one pin state per clock
// while the output register is empty or out_ready is high, and the next
// request is taken once the final state has entered the output register.
// Configuration writes are taken at any time but belong between runs.
`default_nettype none

module char_lcd_nibble_command_sequencer
  import clcd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output      logic                 in_ready,
  input  wire logic [1:0]           in_op,
  input  wire logic [7:0]           in_char_code,
  input  wire logic [2:0]           in_row,
  input  wire logic [4:0]           in_column,
  output      logic                 out_valid,
  input  wire logic                 out_ready,
  output      logic                 out_reg_select,
  output      logic                 out_enable,
  output      logic [3:0]           out_data_nibble,
  output      logic [7:0]           out_wait_ms,
  output      logic                 out_last,
  input  wire logic                 cfg_valid,
  output      logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data
);

  logic [7:0] pow_r;
  logic [3:0] pw_r;
  logic       out_valid_r, out_valid_nxt;
  logic       rs_r, en_r, last_r;
  logic [3:0] nib_r;
  logic [7:0] wait_r;
  logic       step;
  logic       emit;
  logic       e_rs, e_en, e_last;
  logic [3:0] e_nib;
  logic [7:0] e_wait;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pow_r <= POWER_ON_WAIT_RST;
      pw_r  <= PULSE_WAIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_POWER_ON_WAIT) begin
        pow_r <= cfg_data;
      end else if (cfg_index == CFG_PULSE_WAIT) begin
        pw_r <= cfg_data[3:0];
      end
    end
  end

  // sequencer
  assign step = ~out_valid_r | out_ready;

  clcd_seq u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (in_valid),
    .req_ready        (in_ready),
    .op               (in_op),
    .char_code        (in_char_code),
    .row              (in_row),
    .column           (in_column),
    .power_on_wait_ms (pow_r),
    .pulse_wait_ms    (pw_r),
    .step             (step),
    .emit             (emit),
    .emit_reg_select  (e_rs),
    .emit_enable      (e_en),
    .emit_data_nibble (e_nib),
    .emit_wait_ms     (e_wait),
    .emit_last        (e_last)
  );

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (emit) begin
      rs_r   <= e_rs;
      en_r   <= e_en;
      nib_r  <= e_nib;
      wait_r <= e_wait;
      last_r <= e_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_reg_select  = rs_r;
  assign out_enable      = en_r;
  assign out_data_nibble = nib_r;
  assign out_wait_ms     = wait_r;
  assign out_last        = last_r;

  // a run always closes on an enable-low latch state
  a_last_enable_low : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_enable && out_last))
    else $error("run closed on an enable-high state");

  // a character write keeps the request side closed while it runs
  a_write_busy : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_op == OP_WRITE_CHAR)) |=> !in_ready)
    else $error("request taken during a character write");

  // a stalled pin state holds until its transfer
  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid &&
      $stable({out_reg_select, out_enable, out_data_nibble, out_wait_ms, out_last})))
    else $error("pin state changed while stalled");

endmodule

`default_nettype wire

// File: rtl/core/clcd_nib_shift.sv
// ----------------------------------------------------------------------------
// clcd_nib_shift
// Byte shift register that sends one command byte as four pin states, one
// nibble digit at a time with an enable strobe and latch phase per nibble.
// ----------------------------------------------------------------------------
`default_nettype none

module clcd_nib_shift
  import clcd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire shift_ctl_t ctl,
  output      shift_sts_t sts
);

  logic [7:0] byte_r;
  logic [7:0] byte_nxt;
  logic [1:0] phase_r;
  logic [1:0] phase_nxt;

  // load a new byte or step through the nibble phases
  always_comb begin
    byte_nxt  = byte_r;
    phase_nxt = phase_r;
    if (ctl.load) begin
      byte_nxt  = ctl.cmd_byte;
      phase_nxt = PH_HI_STROBE;
    end else if (ctl.advance) begin
      phase_nxt = phase_r + 2'd1;
      if (phase_r == PH_HI_LATCH) begin
        byte_nxt = {byte_r[3:0], 4'b0000};
      end
    end
  end

  // phase is control state, the byte is payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HI_STROBE;
    end else begin
      phase_r <= phase_nxt;
    end
    byte_r <= byte_nxt;
  end

  // current pin state
  assign sts.nibble      = byte_r[7:4];
  assign sts.enable      = ~phase_r[0];
  assign sts.final_state = (phase_r == PH_LO_LATCH);

endmodule

`default_nettype wire

// File: rtl/core/clcd_seq.sv
// ----------------------------------------------------------------------------
// clcd_seq
// Request sequencer: picks the command byte for each request, runs the init
// command list and produces one pin state per step.
// ----------------------------------------------------------------------------
`default_nettype none

module clcd_seq
  import clcd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       req_valid,
  output      logic       req_ready,
  input  wire logic [1:0] op,
  input  wire logic [7:0] char_code,
  input  wire logic [2:0] row,
  input  wire logic [4:0] column,
  input  wire logic [7:0] power_on_wait_ms,
  input  wire logic [3:0] pulse_wait_ms,
  input  wire logic       step,
  output      logic       emit,
  output      logic       emit_reg_select,
  output      logic       emit_enable,
  output      logic [3:0] emit_data_nibble,
  output      logic [7:0] emit_wait_ms,
  output      logic       emit_last
);

  logic       busy_r, busy_nxt;
  logic       init_r, init_nxt;
  logic       pon_r, pon_nxt;
  logic       rs_r, rs_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       accept;
  logic       cursor_ok;
  logic [7:0] cursor_cmd;
  logic [7:0] extra;
  shift_ctl_t sh_ctl;
  shift_sts_t sh_sts;

  clcd_nib_shift u_shift (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (sh_ctl),
    .sts   (sh_sts)
  );

  assign req_ready  = ~busy_r;
  assign accept     = req_valid & req_ready;
  assign emit       = busy_r & step;
  assign cursor_ok  = (row <= MAX_ROW) && (column <= MAX_COLUMN);
  assign cursor_cmd = CMD_SET_DDRAM | (row_base(row[1:0]) + {3'b000, column});

  // extra hold on the closing state of the first two init commands
  always_comb begin
    extra = 8'd0;
    if (init_r && sh_sts.final_state) begin
      if (idx_r == 3'd0) begin
        extra = EXTRA_WAIT_FIRST;
      end else if (idx_r == 3'd1) begin
        extra = EXTRA_WAIT_SECOND;
      end
    end
  end

  // pin state presented for this step
  always_comb begin
    if (pon_r) begin
      emit_reg_select  = 1'b0;
      emit_enable      = 1'b0;
      emit_data_nibble = 4'h0;
      emit_wait_ms     = power_on_wait_ms;
      emit_last        = 1'b0;
    end else begin
      emit_reg_select  = rs_r;
      emit_enable      = sh_sts.enable;
      emit_data_nibble = sh_sts.nibble;
      emit_wait_ms     = {4'h0, pulse_wait_ms} + extra;
      emit_last        = sh_sts.final_state & (~init_r | (idx_r == INIT_LAST_IDX));
    end
  end

  // request decode and run control
  always_comb begin
    busy_nxt        = busy_r;
    init_nxt        = init_r;
    pon_nxt         = pon_r;
    rs_nxt          = rs_r;
    idx_nxt         = idx_r;
    sh_ctl.load     = 1'b0;
    sh_ctl.advance  = 1'b0;
    sh_ctl.cmd_byte = char_code;
    if (accept) begin
      init_nxt    = 1'b0;
      pon_nxt     = 1'b0;
      rs_nxt      = 1'b0;
      idx_nxt     = 3'd0;
      sh_ctl.load = 1'b1;
      case (op)
        OP_WRITE_CHAR: begin
          busy_nxt        = 1'b1;
          rs_nxt          = 1'b1;
          sh_ctl.cmd_byte = char_code;
        end
        OP_CLEAR: begin
          busy_nxt        = 1'b1;
          sh_ctl.cmd_byte = CMD_CLEAR;
        end
        OP_SET_CURSOR: begin
          busy_nxt        = cursor_ok;
          sh_ctl.cmd_byte = cursor_cmd;
        end
        default: begin
          busy_nxt        = 1'b1;
          init_nxt        = 1'b1;
          pon_nxt         = 1'b1;
          sh_ctl.cmd_byte = init_cmd(3'd0);
        end
      endcase
    end else if (emit) begin
      if (pon_r) begin
        pon_nxt = 1'b0;
      end else if (sh_sts.final_state && init_r && (idx_r != INIT_LAST_IDX)) begin
        idx_nxt         = idx_r + 3'd1;
        sh_ctl.load     = 1'b1;
        sh_ctl.cmd_byte = init_cmd(idx_r + 3'd1);
      end else begin
        sh_ctl.advance = 1'b1;
        if (sh_sts.final_state) begin
          busy_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      init_r <= 1'b0;
      pon_r  <= 1'b0;
      rs_r   <= 1'b0;
      idx_r  <= 3'd0;
    end else begin
      busy_r <= busy_nxt;
      init_r <= init_nxt;
      pon_r  <= pon_nxt;
      rs_r   <= rs_nxt;
      idx_r  <= idx_nxt;
    end
  end

endmodule

`default_nettype wire
